@@ sv/che_pkg.sv @@
package che_pkg;

    // Fixed field widths
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int KIND_W  = 2;
    localparam int CFG_W   = 11;
    localparam int TOTAL_W = 11;
    localparam int IDX_W   = 1;

    // Default sizes
    localparam int DEF_MAX_BUCKETS = 1024;
    localparam int DEF_MAX_NODES   = 1024;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_BUCKET_COUNT   = 1'b0;
    localparam logic [IDX_W-1:0] REG_CAPACITY_LIMIT = 1'b1;
    localparam logic [CFG_W-1:0] BUCKET_COUNT_RST   = 11'd1024;
    localparam logic [CFG_W-1:0] CAPACITY_RST       = 11'd1024;

    // Hash constants
    localparam logic [31:0] HASH_C0 = 32'h7ed55d16;
    localparam logic [31:0] HASH_C1 = 32'hc761c23c;
    localparam logic [31:0] HASH_C2 = 32'h165667b1;
    localparam logic [31:0] HASH_C3 = 32'hd3a2646c;
    localparam logic [31:0] HASH_C4 = 32'hfd7046c5;
    localparam logic [31:0] HASH_C5 = 32'hb55a4f09;
    localparam logic [2:0]  HASH_LAST_STEP = 3'd5;
    localparam int          DIV_STEPS = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_GET    = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_UPDATE = 2'd2,
        KIND_REMOVE = 2'd3
    } che_kind_t;

    typedef struct packed {
        logic clr_en;
        logic load;
        logic take_recent;
        logic hash_step;
        logic div_init;
        logic div_step;
        logic head_rd;
        logic head_take;
        logic node_rd;
        logic rd_free;
        logic advance;
        logic set_recent;
        logic get_value;
        logic set_ok;
        logic val_wr;
        logic alloc_free;
        logic alloc_fresh;
        logic ins_wr;
        logic rm_unlink;
        logic rm_free;
        logic out_load;
    } che_cmd_t;

    typedef struct packed {
        logic      clr_last;
        logic      hash_last;
        logic      div_last;
        che_kind_t kind;
        logic      full;
        logic      rec_valid;
        logic      key_match;
        logic      cur_null;
        logic      free_valid;
    } che_sts_t;

    // One round of the integer mix
    function automatic logic [31:0] mix_step(input logic [31:0] h, input logic [2:0] s);
        logic [31:0] r;
        r = h;
        case (s)
            3'd0:    r = (h + HASH_C0) + (h << 12);
            3'd1:    r = (h ^ HASH_C1) ^ (h >> 19);
            3'd2:    r = (h + HASH_C2) + (h << 5);
            3'd3:    r = (h + HASH_C3) ^ (h << 9);
            3'd4:    r = (h + HASH_C4) + (h << 3);
            3'd5:    r = (h ^ HASH_C5) ^ (h >> 16);
            default: r = h;
        endcase
        return r;
    endfunction

endpackage

@@ sv/che_if.sv @@
interface che_req_if import che_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value_in;

    modport source (output valid, kind, key, value_in, input ready);
    modport sink   (input valid, kind, key, value_in, output ready);
endinterface

interface che_rsp_if import che_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               status;
    logic [VAL_W-1:0]   value_out;
    logic [TOTAL_W-1:0] entry_total;

    modport source (output valid, status, value_out, entry_total, input ready);
    modport sink   (input valid, status, value_out, entry_total, output ready);
endinterface

@@ sv/chained_hash_table_engine.sv @@
// Each request: full check, then a recent-node probe (not for removes), 6 hash rounds,
// 32 remainder steps, bucket read, chain walk and insert/remove writes; a recent hit
// skips to the result, and an insert refused as full goes straight to it.
// Throughput: one word at a time; the next request word is taken once the result of
// the previous one is in the output register.
// Reset: asynchronous, active low; then a sweep nulls each of the MAX_BUCKETS bucket
// heads, during which no request is taken (configuration writes still are).
module chained_hash_table_engine import che_pkg::*;
#(
    parameter int MAX_BUCKETS = DEF_MAX_BUCKETS,
    parameter int MAX_NODES   = DEF_MAX_NODES
)
(
    input  logic              clk,
    input  logic              rst_n,
    che_req_if.sink           req,
    che_rsp_if.source         rsp,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    // Controller sequences each request: full check, recent-node probe, hash
    // rounds, remainder by the bucket count, then the chain walk with a read
    // state and a check state per node. Datapath holds the stores and all working registers.
    che_cmd_t cmd;
    che_sts_t sts;

    che_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Results go into an output register; the word there waits while the
    // next request is accepted and worked on.
    che_dp #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .MAX_NODES   (MAX_NODES)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_kind    (req.kind),
        .in_key     (req.key),
        .in_value   (req.value_in),
        .out_status (rsp.status),
        .out_value  (rsp.value_out),
        .out_total  (rsp.entry_total)
    );

endmodule

@@ sv/che_ctrl.sv @@
module che_ctrl import che_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  che_sts_t sts,
    output che_cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_START, ST_REC_RD, ST_REC_CHK, ST_HASH, ST_DIV,
        ST_HEAD_RD, ST_HEAD_TAKE, ST_NODE_RD, ST_NODE_CHK, ST_FOUND,
        ST_FREE_RD, ST_FREE_TAKE, ST_INS_WR, ST_RM_UNLINK, ST_RM_FREE, ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (sts.kind == KIND_INSERT && sts.full)
                    state_next = ST_FINISH;
                else if (sts.kind != KIND_REMOVE && sts.rec_valid)
                begin
                    cmd.take_recent = 1'b1;
                    state_next      = ST_REC_RD;
                end
                else
                    state_next = ST_HASH;
            end
            ST_REC_RD:
            begin
                cmd.node_rd = 1'b1;
                state_next  = ST_REC_CHK;
            end
            ST_REC_CHK:
            begin
                state_next = sts.key_match ? ST_FOUND : ST_HASH;
            end
            ST_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (sts.hash_last)
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = ST_HEAD_RD;
            end
            ST_HEAD_RD:
            begin
                cmd.head_rd = 1'b1;
                state_next  = ST_HEAD_TAKE;
            end
            ST_HEAD_TAKE:
            begin
                cmd.head_take = 1'b1;
                state_next    = ST_NODE_RD;
            end
            ST_NODE_RD:
            begin
                if (sts.cur_null)
                begin
                    if (sts.kind == KIND_INSERT)
                    begin
                        if (sts.free_valid)
                            state_next = ST_FREE_RD;
                        else
                        begin
                            cmd.alloc_fresh = 1'b1;
                            state_next      = ST_INS_WR;
                        end
                    end
                    else
                        state_next = ST_FINISH;
                end
                else
                begin
                    cmd.node_rd = 1'b1;
                    state_next  = ST_NODE_CHK;
                end
            end
            ST_NODE_CHK:
            begin
                if (sts.key_match)
                    state_next = ST_FOUND;
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_NODE_RD;
                end
            end
            ST_FOUND:
            begin
                cmd.set_recent = 1'b1;
                state_next     = ST_FINISH;
                unique case (sts.kind)
                    KIND_GET:
                    begin
                        cmd.get_value = 1'b1;
                        cmd.set_ok    = 1'b1;
                    end
                    KIND_UPDATE:
                    begin
                        cmd.val_wr = 1'b1;
                        cmd.set_ok = 1'b1;
                    end
                    KIND_REMOVE: state_next = ST_RM_UNLINK;
                    default:     state_next = ST_FINISH;
                endcase
            end
            ST_FREE_RD:
            begin
                cmd.node_rd = 1'b1;
                cmd.rd_free = 1'b1;
                state_next  = ST_FREE_TAKE;
            end
            ST_FREE_TAKE:
            begin
                cmd.alloc_free = 1'b1;
                state_next     = ST_INS_WR;
            end
            ST_INS_WR:
            begin
                cmd.ins_wr = 1'b1;
                cmd.set_ok = 1'b1;
                state_next = ST_FINISH;
            end
            ST_RM_UNLINK:
            begin
                cmd.rm_unlink = 1'b1;
                state_next    = ST_RM_FREE;
            end
            ST_RM_FREE:
            begin
                cmd.rm_free = 1'b1;
                cmd.set_ok  = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ sv/che_dp.sv @@
module che_dp import che_pkg::*;
#(
    parameter int MAX_BUCKETS = DEF_MAX_BUCKETS,
    parameter int MAX_NODES   = DEF_MAX_NODES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  che_cmd_t           cmd,
    output che_sts_t           sts,
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic [KIND_W-1:0]  in_kind,
    input  logic [KEY_W-1:0]   in_key,
    input  logic [VAL_W-1:0]   in_value,
    output logic               out_status,
    output logic [VAL_W-1:0]   out_value,
    output logic [TOTAL_W-1:0] out_total
);

    localparam int NW  = $clog2(MAX_NODES + 1);
    localparam int NAW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int BW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int DCW = $clog2(DIV_STEPS);
    localparam logic [NW-1:0] NULL_IDX = NW'(MAX_NODES);

    // Config and control state
    logic [CFG_W-1:0] bucket_cnt_reg, cap_reg;
    logic [NW-1:0]    free_head_reg, count_reg, recent_reg;
    logic [BW-1:0]    clr_cnt_reg;
    logic [2:0]       step_reg;
    logic [DCW-1:0]   div_cnt_reg;

    // Working registers
    che_kind_t        kind_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;
    logic [31:0]      h_reg;
    logic [CFG_W-1:0] rem_reg;
    logic [NW-1:0]    cur_reg, prev_reg, head_save_reg, new_reg;
    logic             res_status_reg;
    logic [VAL_W-1:0] res_value_reg;
    logic               out_status_reg;
    logic [VAL_W-1:0]   out_value_reg;
    logic [TOTAL_W-1:0] out_total_reg;

    // Stores and their read registers
    logic [NW-1:0]    heads_mem [MAX_BUCKETS];
    logic [KEY_W-1:0] keys_mem  [MAX_NODES];
    logic [VAL_W-1:0] vals_mem  [MAX_NODES];
    logic [NW-1:0]    links_mem [MAX_NODES];
    logic [NW-1:0]    head_rd_reg, link_rd_reg;
    logic [KEY_W-1:0] key_rd_reg;
    logic [VAL_W-1:0] val_rd_reg;

    logic [CFG_W-1:0] div_n;
    logic [CFG_W:0]   trial;
    logic [CFG_W:0]   trial_sub;
    logic [31:0]      lim;
    logic [BW-1:0]    bidx;
    logic [NAW-1:0]   node_addr;
    logic             prev_valid;

    always_comb
    begin
        if (bucket_cnt_reg == '0)
            div_n = CFG_W'(1);
        else if (32'(bucket_cnt_reg) > MAX_BUCKETS)
            div_n = CFG_W'(MAX_BUCKETS);
        else
            div_n = bucket_cnt_reg;
        lim = (32'(cap_reg) > MAX_NODES) ? 32'(MAX_NODES) : 32'(cap_reg);
    end

    // restoring remainder, one quotient bit a cycle
    assign trial      = {rem_reg, h_reg[31]};
    assign trial_sub  = trial - {1'b0, div_n};
    assign bidx       = BW'(rem_reg);
    assign node_addr  = cmd.rd_free ? free_head_reg[NAW-1:0] : cur_reg[NAW-1:0];
    assign prev_valid = (prev_reg != NULL_IDX);

    assign sts.clr_last   = (clr_cnt_reg == BW'(MAX_BUCKETS - 1));
    assign sts.hash_last  = (step_reg == HASH_LAST_STEP);
    assign sts.div_last   = (div_cnt_reg == DCW'(DIV_STEPS - 1));
    assign sts.kind       = kind_reg;
    assign sts.full       = (32'(count_reg) >= lim);
    assign sts.rec_valid  = (recent_reg != NULL_IDX);
    assign sts.key_match  = (key_rd_reg == key_reg);
    assign sts.cur_null   = (cur_reg == NULL_IDX);
    assign sts.free_valid = (free_head_reg != NULL_IDX);

    assign out_status = out_status_reg;
    assign out_value  = out_value_reg;
    assign out_total  = out_total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_cnt_reg <= BUCKET_COUNT_RST;
            cap_reg        <= CAPACITY_RST;
            free_head_reg  <= NULL_IDX;
            count_reg      <= '0;
            recent_reg     <= NULL_IDX;
            clr_cnt_reg    <= '0;
            step_reg       <= '0;
            div_cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BUCKET_COUNT:   bucket_cnt_reg <= cfg_data;
                    REG_CAPACITY_LIMIT: cap_reg        <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.clr_en)
                clr_cnt_reg <= clr_cnt_reg + BW'(1);
            if (cmd.load)
                step_reg <= '0;
            else if (cmd.hash_step)
                step_reg <= step_reg + 3'd1;
            if (cmd.div_init)
                div_cnt_reg <= '0;
            else if (cmd.div_step)
                div_cnt_reg <= div_cnt_reg + DCW'(1);
            if (cmd.set_recent)
                recent_reg <= cur_reg;
            if (cmd.alloc_free)
                free_head_reg <= link_rd_reg;
            if (cmd.ins_wr)
            begin
                recent_reg <= new_reg;
                count_reg  <= count_reg + NW'(1);
            end
            if (cmd.rm_free)
            begin
                free_head_reg <= cur_reg;
                recent_reg    <= NULL_IDX;
                if (count_reg != '0)
                    count_reg <= count_reg - NW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg       <= che_kind_t'(in_kind);
            key_reg        <= in_key;
            val_reg        <= in_value;
            h_reg          <= in_key;
            res_status_reg <= 1'b1;
            res_value_reg  <= '0;
        end
        else if (cmd.hash_step)
            h_reg <= mix_step(h_reg, step_reg);
        else if (cmd.div_step)
            h_reg <= {h_reg[30:0], 1'b0};
        if (cmd.div_init)
            rem_reg <= '0;
        else if (cmd.div_step)
            rem_reg <= trial_sub[CFG_W] ? trial[CFG_W-1:0] : trial_sub[CFG_W-1:0];
        if (cmd.take_recent)
            cur_reg <= recent_reg;
        else if (cmd.head_take)
            cur_reg <= head_rd_reg;
        else if (cmd.advance)
            cur_reg <= link_rd_reg;
        if (cmd.head_take)
        begin
            prev_reg      <= NULL_IDX;
            head_save_reg <= head_rd_reg;
        end
        else if (cmd.advance)
            prev_reg <= cur_reg;
        if (cmd.alloc_free)
            new_reg <= free_head_reg;
        else if (cmd.alloc_fresh)
            new_reg <= count_reg;
        if (cmd.set_ok)
            res_status_reg <= 1'b0;
        if (cmd.get_value)
            res_value_reg <= val_rd_reg;
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_value_reg;
            out_total_reg  <= TOTAL_W'(count_reg);
        end
    end

    // Bucket head store: swept to null after reset
    always_ff @(posedge clk)
    begin
        if (cmd.clr_en)
            heads_mem[clr_cnt_reg] <= NULL_IDX;
        else if (cmd.ins_wr)
            heads_mem[bidx] <= new_reg;
        else if (cmd.rm_unlink && !prev_valid)
            heads_mem[bidx] <= link_rd_reg;
        if (cmd.head_rd)
            head_rd_reg <= heads_mem[bidx];
    end

    // Node stores
    always_ff @(posedge clk)
    begin
        if (cmd.ins_wr)
            keys_mem[new_reg[NAW-1:0]] <= key_reg;
        if (cmd.node_rd)
            key_rd_reg <= keys_mem[node_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ins_wr)
            vals_mem[new_reg[NAW-1:0]] <= val_reg;
        else if (cmd.val_wr)
            vals_mem[cur_reg[NAW-1:0]] <= val_reg;
        if (cmd.node_rd)
            val_rd_reg <= vals_mem[node_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ins_wr)
            links_mem[new_reg[NAW-1:0]] <= head_save_reg;
        else if (cmd.rm_unlink && prev_valid)
            links_mem[prev_reg[NAW-1:0]] <= link_rd_reg;
        else if (cmd.rm_free)
            links_mem[cur_reg[NAW-1:0]] <= free_head_reg;
        if (cmd.node_rd)
            link_rd_reg <= links_mem[node_addr];
    end

endmodule

@@ sv/che_checker.sv @@
module che_sva import che_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               status,
    input logic [VAL_W-1:0]   value_out,
    input logic [TOTAL_W-1:0] entry_total
);

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> value_out == '0)
        else $error("failed result carries a value");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(entry_total) <= MAX_NODES)
        else $error("entry total beyond node pool");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value_out) && $stable(status))
        else $error("result word dropped or changed under stall");

endmodule

bind chained_hash_table_engine che_sva #(.MAX_NODES(MAX_NODES)) u_che_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .status      (rsp.status),
    .value_out   (rsp.value_out),
    .entry_total (rsp.entry_total)
);

@@ bench/che_checker.sv @@
module che_checker import che_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    che_req_if          req,
    che_rsp_if          rsp,
    input  logic        cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output int          errors,
    output int          pending
);

    localparam int          NODES    = DEF_MAX_NODES;
    localparam int          BUCKETS  = DEF_MAX_BUCKETS;
    localparam logic [10:0] NIL      = 11'(NODES);
    localparam logic        ST_OK    = 1'b0;
    localparam logic        ST_FAIL  = 1'b1;

    typedef struct packed {
        logic        status;
        logic [31:0] value_out;
        logic [10:0] entry_total;
    } rsp_word_t;

    logic [10:0] buckets_cfg;
    logic [10:0] cap_cfg;
    logic [10:0] heads [BUCKETS];
    logic [31:0] nkeys [NODES];
    logic [31:0] nvals [NODES];
    logic [10:0] nlinks [NODES];
    logic [10:0] free_hd;
    logic [10:0] live_count;
    logic [10:0] recent;

    rsp_word_t   due_q [$];

    function automatic logic [31:0] jenkins_mix(input logic [31:0] k);
        logic [31:0] h;
        h = k;
        h = (h + 32'h7ed55d16) + (h << 12);
        h = (h ^ 32'hc761c23c) ^ (h >> 19);
        h = (h + 32'h165667b1) + (h << 5);
        h = (h + 32'hd3a2646c) ^ (h << 9);
        h = (h + 32'hfd7046c5) + (h << 3);
        h = (h ^ 32'hb55a4f09) ^ (h >> 16);
        return h;
    endfunction

    function automatic int unsigned bucket_for(input logic [31:0] k);
        int unsigned n;
        n = buckets_cfg;
        if (n == 0) n = 1;
        if (n > BUCKETS) n = BUCKETS;
        return jenkins_mix(k) % n;
    endfunction

    // recent-node short-cut, then chain walk; a hit refreshes the recent node
    function automatic logic [10:0] locate(input logic [31:0] k);
        logic [10:0] cur;
        int          steps;
        if (recent < NIL && nkeys[recent] == k)
            return recent;
        cur = heads[bucket_for(k)];
        for (steps = 0; steps < NODES && cur < NIL; steps++)
        begin
            if (nkeys[cur] == k)
            begin
                recent = cur;
                return cur;
            end
            cur = nlinks[cur];
        end
        return NIL;
    endfunction

    function automatic logic table_insert(input logic [31:0] k, input logic [31:0] v);
        int unsigned lim;
        int unsigned b;
        logic [10:0] n;
        lim = cap_cfg;
        if (lim > NODES) lim = NODES;
        if (live_count >= lim) return ST_FAIL;
        if (locate(k) < NIL) return ST_FAIL;
        b = bucket_for(k);
        if (free_hd < NIL)
        begin
            n = free_hd;
            free_hd = nlinks[n];
        end
        else
        begin
            n = live_count;
            if (n >= NIL) return ST_FAIL;
        end
        nkeys[n]  = k;
        nvals[n]  = v;
        nlinks[n] = heads[b];
        heads[b]  = n;
        recent    = n;
        live_count++;
        return ST_OK;
    endfunction

    function automatic logic table_remove(input logic [31:0] k);
        int unsigned b;
        logic [10:0] cur;
        logic [10:0] prev;
        int          steps;
        b    = bucket_for(k);
        cur  = heads[b];
        prev = NIL;
        for (steps = 0; steps < NODES && cur < NIL; steps++)
        begin
            if (nkeys[cur] == k)
            begin
                if (prev < NIL) nlinks[prev] = nlinks[cur];
                else            heads[b] = nlinks[cur];
                nlinks[cur] = free_hd;
                free_hd     = cur;
                if (live_count > 0) live_count--;
                recent = NIL;
                return ST_OK;
            end
            prev = cur;
            cur  = nlinks[cur];
        end
        return ST_FAIL;
    endfunction

    function automatic rsp_word_t table_apply(input che_kind_t k, input logic [31:0] key,
                                              input logic [31:0] v);
        rsp_word_t   r;
        logic [10:0] n;
        r.status    = ST_FAIL;
        r.value_out = '0;
        case (k)
            KIND_GET:
            begin
                n = locate(key);
                if (n < NIL)
                begin
                    r.status    = ST_OK;
                    r.value_out = nvals[n];
                end
            end
            KIND_INSERT: r.status = table_insert(key, v);
            KIND_UPDATE:
            begin
                n = locate(key);
                if (n < NIL)
                begin
                    r.status = ST_OK;
                    nvals[n] = v;
                end
            end
            default:     r.status = table_remove(key);
        endcase
        r.entry_total = live_count;
        return r;
    endfunction

    assign pending = due_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        rsp_word_t exp_w;
        if (!rst_n)
        begin
            buckets_cfg <= BUCKET_COUNT_RST;
            cap_cfg     <= CAPACITY_RST;
            free_hd     = NIL;
            live_count  = '0;
            recent      = NIL;
            for (int i = 0; i < BUCKETS; i++) heads[i] = NIL;
            for (int i = 0; i < NODES; i++)
            begin
                nkeys[i]  = '0;
                nvals[i]  = '0;
                nlinks[i] = '0;
            end
            due_q.delete();
            errors = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_BUCKET_COUNT) buckets_cfg <= cfg_data;
                else                               cap_cfg     <= cfg_data;
            end
            // result first: a request accepted this edge cannot have its result yet
            if (rsp.valid && rsp.ready)
            begin
                if (due_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result word: st=%0d val=%h tot=%0d",
                                 rsp.status, rsp.value_out, rsp.entry_total);
                end
                else
                begin
                    exp_w = due_q.pop_front();
                    if (rsp.status !== exp_w.status || rsp.value_out !== exp_w.value_out ||
                        rsp.entry_total !== exp_w.entry_total)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp st=%0d val=%h tot=%0d, got st=%0d val=%h tot=%0d",
                                     exp_w.status, exp_w.value_out, exp_w.entry_total,
                                     rsp.status, rsp.value_out, rsp.entry_total);
                    end
                end
            end
            if (req.valid && req.ready)
                due_q.push_back(table_apply(che_kind_t'(req.kind), req.key, req.value_in));
        end
    end

endmodule

@@ bench/chained_hash_table_engine_tb.sv @@
module chained_hash_table_engine_tb;
    import che_pkg::*;

    // cycles with no word moving before the run is declared hung;
    // covers the reset sweep, a long chain walk and the output hold-off
    localparam int WATCHDOG = 8000;
    localparam int POOL     = 48;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    int               errors;
    int               pending;
    int               stall_cnt;
    bit               quiet;      // no idling on either side while set
    bit               hold_req;   // asks the output side for long hold-offs
    logic [31:0]      key_pool [POOL];

    che_req_if req ();
    che_rsp_if rsp ();

    chained_hash_table_engine u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    che_checker u_chk
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 90);
    endfunction

    // output side: random ready, plus long hold-offs while they are requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            stall_cnt <= 0;
        end
        else if (stall_cnt > 0)
        begin
            rsp.ready <= 1'b0;
            stall_cnt <= stall_cnt - 1;
        end
        else if (hold_req && rsp.ready)
        begin
            rsp.ready <= 1'b0;
            stall_cnt <= 600;
        end
        else
            rsp.ready <= (pick_gap() == 0);
    end

    // hang detector: counts edges with no word on either channel
    always @(posedge clk)
    begin
        int idle_cycles;
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("chained_hash_table_engine_tb: done, errors");
            $finish;
        end
    end

    // one request word; ready is read mid-cycle, the accepting edge follows
    task automatic send_word(input che_kind_t k, input logic [31:0] key,
                             input logic [31:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid    <= 1'b1;
        req.kind     <= k;
        req.key      <= key;
        req.value_in <= v;
        @(negedge clk);
        while (!req.ready) @(negedge clk);
        @(posedge clk);
    endtask

    // both registers, only with the table quiet; the negedge lets the
    // checker log a word accepted at the edge just passed
    task automatic set_regs(input logic [CFG_W-1:0] nbuckets, input logic [CFG_W-1:0] cap);
        req.valid <= 1'b0;
        @(negedge clk);
        wait (pending == 0);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_BUCKET_COUNT;
        cfg_data  <= nbuckets;
        @(posedge clk);
        cfg_index <= REG_CAPACITY_LIMIT;
        cfg_data  <= cap;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_phase(input int n);
        int          r;
        che_kind_t   k;
        logic [31:0] key;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)      k = KIND_INSERT;
            else if (r < 60) k = KIND_GET;
            else if (r < 75) k = KIND_UPDATE;
            else             k = KIND_REMOVE;
            // pool keys give hits, duplicates and real removes; the rest miss
            if ($urandom_range(0, 9) == 0) key = $urandom;
            else                           key = key_pool[$urandom_range(0, POOL - 1)];
            send_word(k, key, $urandom);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        quiet        = 1'b0;
        hold_req     = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_BUCKET_COUNT;
        cfg_data     = '0;
        req.valid    = 1'b0;
        req.kind     = KIND_GET;
        req.key      = '0;
        req.value_in = '0;
        for (int i = 0; i < POOL; i++) key_pool[i] = $urandom;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hffff_ffff;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, each operation, duplicate, absent key, node reuse
        send_word(KIND_INSERT, 32'h0000_0000, 32'hffff_ffff);
        send_word(KIND_INSERT, 32'hffff_ffff, 32'h0000_0000);
        send_word(KIND_GET,    32'h0000_0000, 32'h1234_5678);
        send_word(KIND_GET,    32'hffff_ffff, 32'h0);
        send_word(KIND_INSERT, 32'h0000_0000, 32'h5555_5555);
        send_word(KIND_UPDATE, 32'h0000_0000, 32'haaaa_aaaa);
        send_word(KIND_GET,    32'h0000_0000, 32'h0);
        send_word(KIND_UPDATE, 32'h8000_0001, 32'h1);
        send_word(KIND_GET,    32'h8000_0001, 32'h0);
        send_word(KIND_REMOVE, 32'h0000_0000, 32'h0);
        send_word(KIND_REMOVE, 32'h0000_0000, 32'h0);
        send_word(KIND_GET,    32'h0000_0000, 32'h0);
        send_word(KIND_INSERT, 32'h7fff_fffe, 32'hdead_beef);
        send_word(KIND_GET,    32'h7fff_fffe, 32'h0);
        send_word(KIND_GET,    32'hffff_ffff, 32'h0);

        // zero buckets act as one; entries left in old chains may now miss
        set_regs(11'd0, 11'd16);
        random_phase(260);

        // saturated bucket count and capacity, no idling, with the hold-offs
        set_regs(11'd2047, 11'd2047);
        quiet    = 1'b1;
        hold_req = 1'b1;
        random_phase(40);
        hold_req = 1'b0;
        random_phase(200);
        quiet = 1'b0;

        // nothing may be inserted
        set_regs(11'd7, 11'd0);
        random_phase(150);

        // one long chain
        set_regs(11'd1, 11'd40);
        random_phase(300);

        set_regs(11'd1024, 11'd5);
        random_phase(250);

        set_regs(11'd3, 11'd1024);
        random_phase(485);

        req.valid <= 1'b0;
        @(negedge clk);
        wait (pending == 0);
        repeat (100) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("chained_hash_table_engine_tb: done, clean");
        else
            $display("chained_hash_table_engine_tb: done, errors");
        $finish;
    end

endmodule
